// ===== hdl/lmdd_pkg.sv =====
// ----------------------------------------------------------------------------
// lmdd_pkg
// Shared constants, codes and controller/datapath types for the layered
// decision diagram membership lookup.
// ----------------------------------------------------------------------------
package lmdd_pkg;

  localparam int LAYER_COUNT     = 10;
  localparam int SYMBOL_BITS     = 6;
  localparam int NODES_PER_LAYER = 4096;
  localparam int EDGES_PER_LAYER = 16384;

  localparam int LAYER_BITS = 4;
  localparam int NODE_BITS  = 12;
  localparam int SLOT_BITS  = 14;
  localparam int SPAN_BITS  = 15;
  localparam int KEY_BITS   = LAYER_COUNT * SYMBOL_BITS;
  localparam int EDGE_WORD_BITS = SYMBOL_BITS + NODE_BITS;
  localparam int SPAN_WORD_BITS = 2 * SPAN_BITS;

  localparam int NODE_DEPTH     = LAYER_COUNT * NODES_PER_LAYER;
  localparam int EDGE_DEPTH     = LAYER_COUNT * EDGES_PER_LAYER;
  localparam int NODE_ADDR_BITS = LAYER_BITS + NODE_BITS;
  localparam int EDGE_ADDR_BITS = LAYER_BITS + SLOT_BITS;

  localparam int IN_DATA_BITS  = 128;
  localparam int IN_USER_BITS  = 2;
  localparam int OUT_DATA_BITS = 8;

  typedef enum logic [1:0] {
    REQ_NODE   = 2'd0,
    REQ_EDGE   = 2'd1,
    REQ_LOOKUP = 2'd2
  } req_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_NODE_RD,
    ST_NODE_WAIT,
    ST_SEARCH,
    ST_SEARCH_WAIT,
    ST_CHECK_WAIT,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic [LAYER_BITS-1:0]  layer_index;
    logic [SLOT_BITS-1:0]   entry_index;
    logic [SPAN_BITS-1:0]   span_offset;
    logic [SPAN_BITS-1:0]   span_length;
    logic [SYMBOL_BITS-1:0] edge_symbol;
    logic [NODE_BITS-1:0]   edge_target;
    logic [KEY_BITS-1:0]    position_key;
  } req_t;

  typedef struct packed {
    logic take;
    logic start;
    logic node_rd;
    logic span_ld;
    logic edge_rd_mid;
    logic step;
    logic edge_rd_lo;
    logic advance;
    logic mark_pass;
    logic mark_fail;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic srch_open;
    logic at_end;
    logic match;
    logic last_layer;
    logic out_free;
  } sts_t;

endpackage

// ===== hdl/layered_mdd_membership_lookup_core.sv =====
// ----------------------------------------------------------------------------
// layered_mdd_membership_lookup_core
// Membership lookup over a ten-layer decision diagram held in on-chip memory.
// ----------------------------------------------------------------------------
// The slave stream carries load and lookup beats; tuser selects the kind.
// A node-span or edge load beat is written into its layer's memory in the
// cycle it is accepted and yields no result. A lookup beat walks from the
// root node layer by layer until a layer fails or the last one matches, and
// yields one result beat on the master stream: accepted, and the first
// failing layer (ten when accepted). Per layer, a lookup does a node read,
// one binary-search step per halving of the span (up to fifteen steps, each
// an edge read) and a final edge read unless the search ran off the span;
// a result hand-off ends the lookup. All reads share the single read port of
// the node memory and of the edge memory.
// The slave side is ready only between lookups. A finished result sits in
// an output register, so the next beat is taken while it waits; a second
// result holds the block until the master side takes the first.
// Reset clears the control state and sets root_node to zero; memory
// contents are undefined until written. The user writes root_node through
// cfg_we_i/cfg_wdata_i only while the block is idle; the block does not enforce it.
// ----------------------------------------------------------------------------
module layered_mdd_membership_lookup_core
  import lmdd_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [NODE_BITS-1:0]     cfg_wdata_i,
  input  logic                     s_axis_tvalid,
  output logic                     s_axis_tready,
  // layer_index, entry_index, span_offset, span_length, edge_symbol,
  // edge_target, position_key, zero fill
  input  logic [IN_DATA_BITS-1:0]  s_axis_tdata,
  // req_type
  input  logic [IN_USER_BITS-1:0]  s_axis_tuser,
  output logic                     m_axis_tvalid,
  input  logic                     m_axis_tready,
  // accepted, fail_layer, zero fill
  output logic [OUT_DATA_BITS-1:0] m_axis_tdata
);

  logic [NODE_BITS-1:0]  root_q;
  req_t                  req;
  cmd_t                  cmd;
  sts_t                  sts;
  logic                  res_acc;
  logic [LAYER_BITS-1:0] res_layer;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      root_q <= '0;
    end else if (cfg_we_i) begin
      root_q <= cfg_wdata_i;
    end
  end

  assign req.layer_index  = s_axis_tdata[3:0];
  assign req.entry_index  = s_axis_tdata[17:4];
  assign req.span_offset  = s_axis_tdata[32:18];
  assign req.span_length  = s_axis_tdata[47:33];
  assign req.edge_symbol  = s_axis_tdata[53:48];
  assign req.edge_target  = s_axis_tdata[65:54];
  assign req.position_key = s_axis_tdata[125:66];

  lmdd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_kind_i  (s_axis_tuser),
    .sts_i      (sts),
    .in_ready_o (s_axis_tready),
    .cmd_o      (cmd)
  );

  lmdd_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .in_kind_i        (s_axis_tuser),
    .req_i            (req),
    .root_i           (root_q),
    .out_ready_i      (m_axis_tready),
    .sts_o            (sts),
    .out_valid_o      (m_axis_tvalid),
    .out_accepted_o   (res_acc),
    .out_fail_layer_o (res_layer)
  );

  assign m_axis_tdata = {3'b000, res_layer, res_acc};

  a_fail_layer_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (res_layer <= LAYER_BITS'(LAYER_COUNT)))
    else $error("fail_layer beyond layer count");

  a_accept_layer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && res_acc) |-> (res_layer == LAYER_BITS'(LAYER_COUNT)))
    else $error("accepted result with a failing layer");

  a_lookup_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready && (s_axis_tuser == REQ_LOOKUP))
    |=> !s_axis_tready)
    else $error("ready during a lookup");

endmodule

// ===== hdl/lmdd_ctrl.sv =====
// ----------------------------------------------------------------------------
// lmdd_ctrl
// Sequencer for load beats and the layer-by-layer lower-bound search.
// ----------------------------------------------------------------------------
module lmdd_ctrl
  import lmdd_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic [1:0] in_kind_i,
  input  sts_t       sts_i,
  output logic       in_ready_o,
  output cmd_t       cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i && (in_kind_i == REQ_LOOKUP)) begin
          state_d = ST_NODE_RD;
        end
      end
      ST_NODE_RD:     state_d = ST_NODE_WAIT;
      ST_NODE_WAIT:   state_d = ST_SEARCH;
      ST_SEARCH: begin
        if (sts_i.srch_open) begin
          state_d = ST_SEARCH_WAIT;
        end else if (sts_i.at_end) begin
          state_d = ST_DONE;
        end else begin
          state_d = ST_CHECK_WAIT;
        end
      end
      ST_SEARCH_WAIT: state_d = ST_SEARCH;
      ST_CHECK_WAIT: begin
        if (sts_i.match && !sts_i.last_layer) begin
          state_d = ST_NODE_RD;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (sts_i.out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o   = 1'b1;
        cmd_o.take   = in_valid_i;
        cmd_o.start  = in_valid_i && (in_kind_i == REQ_LOOKUP);
      end
      ST_NODE_RD:     cmd_o.node_rd = 1'b1;
      ST_NODE_WAIT:   cmd_o.span_ld = 1'b1;
      ST_SEARCH: begin
        if (sts_i.srch_open) begin
          cmd_o.edge_rd_mid = 1'b1;
        end else if (sts_i.at_end) begin
          cmd_o.mark_fail = 1'b1;
        end else begin
          cmd_o.edge_rd_lo = 1'b1;
        end
      end
      ST_SEARCH_WAIT: cmd_o.step = 1'b1;
      ST_CHECK_WAIT: begin
        if (!sts_i.match) begin
          cmd_o.mark_fail = 1'b1;
        end else if (sts_i.last_layer) begin
          cmd_o.mark_pass = 1'b1;
        end else begin
          cmd_o.advance = 1'b1;
        end
      end
      ST_DONE:        cmd_o.out_load = sts_i.out_free;
      default: begin
        cmd_o      = '0;
        in_ready_o = 1'b0;
      end
    endcase
  end

endmodule

// ===== hdl/lmdd_dp.sv =====
// ----------------------------------------------------------------------------
// lmdd_dp
// Node span and edge memories, search bounds, key shifter and result register.
// ----------------------------------------------------------------------------
module lmdd_dp
  import lmdd_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  cmd_t                  cmd_i,
  input  logic [1:0]            in_kind_i,
  input  req_t                  req_i,
  input  logic [NODE_BITS-1:0]  root_i,
  input  logic                  out_ready_i,
  output sts_t                  sts_o,
  output logic                  out_valid_o,
  output logic                  out_accepted_o,
  output logic [LAYER_BITS-1:0] out_fail_layer_o
);

  logic [SPAN_WORD_BITS-1:0] node_mem [NODE_DEPTH];
  logic [EDGE_WORD_BITS-1:0] edge_mem [EDGE_DEPTH];

  logic [SPAN_WORD_BITS-1:0] node_rdata_q;
  logic [EDGE_WORD_BITS-1:0] edge_rdata_q;

  logic [LAYER_BITS-1:0] layer_q, layer_d;
  logic [NODE_BITS-1:0]  node_q, node_d;
  logic [KEY_BITS-1:0]   key_q, key_d;
  logic [SPAN_BITS-1:0]  lo_q, lo_d, hi_q, hi_d, end_q, end_d;
  logic                  pass_q, pass_d;

  logic                  out_valid_q;
  logic                  out_acc_q;
  logic [LAYER_BITS-1:0] out_layer_q;

  logic                      node_we, edge_we, edge_rd;
  logic [NODE_ADDR_BITS-1:0] node_waddr, node_raddr;
  logic [EDGE_ADDR_BITS-1:0] edge_waddr, edge_raddr;
  logic [SPAN_BITS-1:0]      mid, span_lo, span_end, slot;
  logic [SPAN_BITS:0]        span_sum;
  logic [SYMBOL_BITS-1:0]    sym, edge_sym;

  assign node_we = cmd_i.take && (in_kind_i == REQ_NODE)
                   && (req_i.layer_index < LAYER_BITS'(LAYER_COUNT))
                   && (req_i.entry_index < SLOT_BITS'(NODES_PER_LAYER));
  assign edge_we = cmd_i.take && (in_kind_i == REQ_EDGE)
                   && (req_i.layer_index < LAYER_BITS'(LAYER_COUNT));
  assign node_waddr = {req_i.layer_index, req_i.entry_index[NODE_BITS-1:0]};
  assign edge_waddr = {req_i.layer_index, req_i.entry_index};
  assign node_raddr = {layer_q, node_q};

  assign mid     = lo_q + ((hi_q - lo_q) >> 1);
  assign edge_rd = cmd_i.edge_rd_mid || cmd_i.edge_rd_lo;
  assign slot    = cmd_i.edge_rd_mid ? mid : lo_q;
  assign edge_raddr = {layer_q, slot[SLOT_BITS-1:0]};

  always_ff @(posedge clk_i) begin
    if (node_we) begin
      node_mem[node_waddr] <= {req_i.span_length, req_i.span_offset};
    end
    if (cmd_i.node_rd) begin
      node_rdata_q <= node_mem[node_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (edge_we) begin
      edge_mem[edge_waddr] <= {req_i.edge_target, req_i.edge_symbol};
    end
    if (edge_rd) begin
      edge_rdata_q <= edge_mem[edge_raddr];
    end
  end

  assign span_sum = {1'b0, node_rdata_q[SPAN_BITS-1:0]}
                    + {1'b0, node_rdata_q[SPAN_WORD_BITS-1:SPAN_BITS]};
  assign span_end = (span_sum > (SPAN_BITS+1)'(EDGES_PER_LAYER)) ?
                    SPAN_BITS'(EDGES_PER_LAYER) : span_sum[SPAN_BITS-1:0];
  assign span_lo  = (node_rdata_q[SPAN_BITS-1:0] > span_end) ?
                    span_end : node_rdata_q[SPAN_BITS-1:0];

  assign sym      = key_q[SYMBOL_BITS-1:0];
  assign edge_sym = edge_rdata_q[SYMBOL_BITS-1:0];

  always_comb begin
    layer_d = layer_q;
    node_d  = node_q;
    key_d   = key_q;
    lo_d    = lo_q;
    hi_d    = hi_q;
    end_d   = end_q;
    pass_d  = pass_q;
    if (cmd_i.start) begin
      layer_d = '0;
      node_d  = root_i;
      key_d   = req_i.position_key;
    end
    if (cmd_i.span_ld) begin
      lo_d  = span_lo;
      hi_d  = span_end;
      end_d = span_end;
    end
    if (cmd_i.step) begin
      if (edge_sym < sym) begin
        lo_d = mid + 1'b1;
      end else begin
        hi_d = mid;
      end
    end
    if (cmd_i.advance) begin
      layer_d = layer_q + 1'b1;
      node_d  = edge_rdata_q[EDGE_WORD_BITS-1:SYMBOL_BITS];
      key_d   = key_q >> SYMBOL_BITS;
    end
    if (cmd_i.mark_pass) begin
      pass_d = 1'b1;
    end
    if (cmd_i.mark_fail) begin
      pass_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    layer_q <= layer_d;
    node_q  <= node_d;
    key_q   <= key_d;
    lo_q    <= lo_d;
    hi_q    <= hi_d;
    end_q   <= end_d;
    pass_q  <= pass_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_acc_q   <= pass_q;
      out_layer_q <= pass_q ? LAYER_BITS'(LAYER_COUNT) : layer_q;
    end
  end

  assign sts_o.srch_open  = lo_q < hi_q;
  assign sts_o.at_end     = lo_q == end_q;
  assign sts_o.match      = edge_sym == sym;
  assign sts_o.last_layer = layer_q == LAYER_BITS'(LAYER_COUNT - 1);
  assign sts_o.out_free   = !out_valid_q || out_ready_i;

  assign out_valid_o      = out_valid_q;
  assign out_accepted_o   = out_acc_q;
  assign out_fail_layer_o = out_layer_q;

endmodule

// ===== bench/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the layered decision diagram membership lookup.
// Load beats build small diagrams in the node and edge memories, and lookup
// beats walk them; a local model of the tables predicts every result beat,
// which the monitor compares field by field. Every lookup only ever reaches
// table entries that were loaded before it, and the run steps through
// several root settings and three patterns of back-pressure.
// ----------------------------------------------------------------------------
module tb_top;
  import lmdd_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] REQ_RESERVED = 2'd3;
  localparam int PACK_BITS    = LAYER_BITS + SLOT_BITS + 2 * SPAN_BITS + SYMBOL_BITS +
                                NODE_BITS + KEY_BITS;
  localparam int DRAIN_CYCLES = 400;
  localparam int STALL_LIMIT  = 20000;
  localparam int PHASES       = 6;
  localparam int LOOKUPS_PER_PHASE = 28;
  localparam int LIVE_MAX     = 64;

  typedef struct packed {
    logic [1:0]             req_type;
    logic [LAYER_BITS-1:0]  layer_index;
    logic [SLOT_BITS-1:0]   entry_index;
    logic [SPAN_BITS-1:0]   span_offset;
    logic [SPAN_BITS-1:0]   span_length;
    logic [SYMBOL_BITS-1:0] edge_symbol;
    logic [NODE_BITS-1:0]   edge_target;
    logic [KEY_BITS-1:0]    position_key;
  } beat_t;

  typedef struct packed {
    logic       accepted;
    logic [3:0] fail_layer;
  } verdict_t;

  logic clk_i = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [NODE_BITS-1:0] cfg_wdata = '0;
  logic s_valid_q = 1'b0;
  logic [IN_DATA_BITS-1:0] s_data_q = '0;
  logic [IN_USER_BITS-1:0] s_user_q = '0;
  logic m_ready_q = 1'b0;
  logic s_axis_tready;
  logic m_axis_tvalid;
  logic [OUT_DATA_BITS-1:0] m_axis_tdata;

  logic [SPAN_WORD_BITS-1:0] span_mem [NODE_DEPTH];
  logic [EDGE_WORD_BITS-1:0] edge_mem [EDGE_DEPTH];
  logic [NODE_BITS-1:0] root_q = '0;

  beat_t    beat_queue [$];
  verdict_t verdict_fifo [$];
  beat_t    cur_beat;

  int live_ids [LAYER_COUNT][LIVE_MAX];
  int live_cnt [LAYER_COUNT];

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int mismatches = 0;
  int stall_cycles = 0;
  int load_beats = 0;
  int ignored_beats = 0;
  int lookup_beats = 0;
  int pass_lookups = 0;
  int root_writes = 0;

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  layered_mdd_membership_lookup_core u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_n),
    .cfg_we_i      (cfg_we),
    .cfg_wdata_i   (cfg_wdata),
    .s_axis_tvalid (s_valid_q),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_data_q),
    .s_axis_tuser  (s_user_q),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_ready_q),
    .m_axis_tdata  (m_axis_tdata)
  );

  function automatic int search_layer(int d, int node, logic [SYMBOL_BITS-1:0] sym);
    logic [SPAN_WORD_BITS-1:0] span;
    logic [EDGE_WORD_BITS-1:0] word;
    int lo, hi, stop, mid;
    if (node >= NODES_PER_LAYER) return -1;
    span = span_mem[d * NODES_PER_LAYER + node];
    lo = int'(span[SPAN_BITS-1:0]);
    stop = lo + int'(span[SPAN_WORD_BITS-1:SPAN_BITS]);
    if (stop > EDGES_PER_LAYER) stop = EDGES_PER_LAYER;
    if (lo > stop) lo = stop;
    hi = stop;
    while (lo < hi) begin
      mid = lo + (hi - lo) / 2;
      word = edge_mem[d * EDGES_PER_LAYER + mid];
      if (word[SYMBOL_BITS-1:0] < sym) lo = mid + 1;
      else hi = mid;
    end
    if (lo == stop) return -1;
    word = edge_mem[d * EDGES_PER_LAYER + lo];
    if (word[SYMBOL_BITS-1:0] != sym) return -1;
    return int'(word[EDGE_WORD_BITS-1:SYMBOL_BITS]);
  endfunction

  function automatic verdict_t walk_diagram(logic [KEY_BITS-1:0] key);
    verdict_t v;
    int node, d;
    v.accepted = 1'b1;
    v.fail_layer = LAYER_BITS'(LAYER_COUNT);
    node = int'(root_q);
    for (d = 0; d < LAYER_COUNT; d++) begin
      node = search_layer(d, node, key[SYMBOL_BITS*d +: SYMBOL_BITS]);
      if (node < 0) begin
        v.accepted = 1'b0;
        v.fail_layer = LAYER_BITS'(d);
        return v;
      end
    end
    return v;
  endfunction

  function automatic void apply_beat(beat_t b);
    case (b.req_type)
      REQ_NODE: begin
        if (b.layer_index < LAYER_COUNT && b.entry_index < NODES_PER_LAYER) begin
          span_mem[b.layer_index * NODES_PER_LAYER + b.entry_index] =
            {b.span_length, b.span_offset};
          load_beats++;
        end else ignored_beats++;
      end
      REQ_EDGE: begin
        if (b.layer_index < LAYER_COUNT && b.entry_index < EDGES_PER_LAYER) begin
          edge_mem[b.layer_index * EDGES_PER_LAYER + b.entry_index] =
            {b.edge_target, b.edge_symbol};
          load_beats++;
        end else ignored_beats++;
      end
      REQ_LOOKUP: begin
        verdict_fifo.insert(verdict_fifo.size(), walk_diagram(b.position_key));
        lookup_beats++;
      end
      default: ignored_beats++;
    endcase
  endfunction

  function automatic logic [IN_DATA_BITS-1:0] pack_beat(beat_t b);
    logic [IN_DATA_BITS-1:0] w;
    w = '0;
    w[PACK_BITS-1:0] = {b.position_key, b.edge_target, b.edge_symbol, b.span_length,
                        b.span_offset, b.entry_index, b.layer_index};
    return w;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    mismatches++;
    $display("MISMATCH at %0t ns: %s: got %0d, expected %0d", $time, what, got, want);
  endtask

  task automatic check_verdict(logic [OUT_DATA_BITS-1:0] data);
    verdict_t want;
    if (verdict_fifo.size() == 0) begin
      report_mismatch("result beat with no lookup outstanding", int'(data), -1);
    end else begin
      want = verdict_fifo.pop_front();
      if (data[0] !== want.accepted)
        report_mismatch("accepted", int'(data[0]), int'(want.accepted));
      if (data[4:1] !== want.fail_layer)
        report_mismatch("fail_layer", int'(data[4:1]), int'(want.fail_layer));
      if (want.accepted) pass_lookups++;
    end
  endtask

  always @(posedge clk_i or negedge rst_n) begin
    if (!rst_n) begin
      s_valid_q <= 1'b0;
    end else begin
      if (s_valid_q && s_axis_tready) apply_beat(cur_beat);
      if (!s_valid_q || s_axis_tready) begin
        if (beat_queue.size() > 0 && $urandom_range(99, 0) >= send_idle_pct) begin
          cur_beat = beat_queue.pop_front();
          s_data_q <= pack_beat(cur_beat);
          s_user_q <= cur_beat.req_type;
          s_valid_q <= 1'b1;
        end else begin
          s_valid_q <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_n) begin
    if (!rst_n) begin
      m_ready_q <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_ready_q) check_verdict(m_axis_tdata);
      m_ready_q <= ($urandom_range(99, 0) >= recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_n) begin
      if ((s_valid_q && s_axis_tready) || (m_axis_tvalid && m_ready_q)) stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("Watchdog: no beat moved for %0d cycles", STALL_LIMIT);
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  function automatic beat_t random_beat();
    beat_t b;
    b.req_type = 2'($urandom_range(3, 0));
    b.layer_index = LAYER_BITS'($urandom_range(15, 0));
    b.entry_index = SLOT_BITS'($urandom);
    b.span_offset = SPAN_BITS'($urandom);
    b.span_length = SPAN_BITS'($urandom);
    b.edge_symbol = SYMBOL_BITS'($urandom);
    b.edge_target = NODE_BITS'($urandom);
    b.position_key = KEY_BITS'({$urandom, $urandom});
    return b;
  endfunction

  task automatic add_node_beat(int d, int id, int off, int len);
    beat_t b;
    b = random_beat();
    b.req_type = REQ_NODE;
    b.layer_index = LAYER_BITS'(d);
    b.entry_index = SLOT_BITS'(id);
    b.span_offset = SPAN_BITS'(off);
    b.span_length = SPAN_BITS'(len);
    beat_queue.insert(beat_queue.size(), b);
  endtask

  task automatic add_edge_beat(int d, int slot, int sym, int tgt);
    beat_t b;
    b = random_beat();
    b.req_type = REQ_EDGE;
    b.layer_index = LAYER_BITS'(d);
    b.entry_index = SLOT_BITS'(slot);
    b.edge_symbol = SYMBOL_BITS'(sym);
    b.edge_target = NODE_BITS'(tgt);
    beat_queue.insert(beat_queue.size(), b);
  endtask

  task automatic add_lookup_beat(logic [KEY_BITS-1:0] key);
    beat_t b;
    b = random_beat();
    b.req_type = REQ_LOOKUP;
    b.position_key = key;
    beat_queue.insert(beat_queue.size(), b);
  endtask

  task automatic add_noise_beat();
    beat_t b;
    b = random_beat();
    case ($urandom_range(2, 0))
      0: b.req_type = REQ_RESERVED;
      1: begin
        b.req_type = REQ_NODE;
        if (b.layer_index < LAYER_COUNT)
          b.entry_index = SLOT_BITS'($urandom_range(2 ** SLOT_BITS - 1, NODES_PER_LAYER));
      end
      default: begin
        b.req_type = REQ_EDGE;
        b.layer_index = LAYER_BITS'($urandom_range(15, LAYER_COUNT));
      end
    endcase
    beat_queue.insert(beat_queue.size(), b);
  endtask

  task automatic add_live(int d, int id);
    int i;
    for (i = 0; i < live_cnt[d]; i++)
      if (live_ids[d][i] == id) return;
    if (live_cnt[d] < LIVE_MAX) begin
      live_ids[d][live_cnt[d]] = id;
      live_cnt[d]++;
    end
  endtask

  function automatic int pick_live(int d);
    return live_ids[d][$urandom_range(live_cnt[d] - 1, 0)];
  endfunction

  // Every node written gets all slots of its clipped span written too, and
  // edges outside the last layer only point at nodes that are loaded, so any
  // walk stays on loaded entries.
  task automatic make_node(int d, int id);
    int roll, cnt, off, len, sym, i, tgt;
    bit sorted;
    roll = $urandom_range(99, 0);
    cnt = 0;
    if (roll < 6) begin
      off = $urandom_range(32767, EDGES_PER_LAYER);
      len = $urandom_range(32767, 0);
    end else if (roll < 12) begin
      off = $urandom_range(32767, 0);
      len = 0;
    end else if (roll < 27) begin
      cnt = $urandom_range(3, 1);
      off = EDGES_PER_LAYER - cnt;
      len = $urandom_range(32767, cnt);
    end else begin
      cnt = $urandom_range(6, 1);
      off = $urandom_range(EDGES_PER_LAYER - cnt, 0);
      len = cnt;
    end
    add_node_beat(d, id, off, len);
    sorted = ($urandom_range(99, 0) < 80);
    sym = $urandom_range(40, 0);
    for (i = 0; i < cnt; i++) begin
      if (!sorted) sym = $urandom_range(63, 0);
      else if (i > 0) sym = sym + $urandom_range(12, 0);
      if (sym > 63) sym = 63;
      tgt = (d == LAYER_COUNT - 1) ? $urandom_range(NODES_PER_LAYER - 1, 0) : pick_live(d + 1);
      add_edge_beat(d, off + i, sym, tgt);
    end
  endtask

  task automatic build_diagram(bit with_top_root);
    int d, k, n, id;
    for (d = LAYER_COUNT - 1; d >= 0; d--) begin
      n = $urandom_range(2, 1);
      for (k = 0; k < n; k++) begin
        if (with_top_root && d == 0 && k == 0) id = NODES_PER_LAYER - 1;
        else id = $urandom_range(NODES_PER_LAYER - 1, 0);
        add_live(d, id);
        make_node(d, id);
      end
    end
  endtask

  function automatic logic [KEY_BITS-1:0] trace_key();
    logic [KEY_BITS-1:0] key;
    logic [SPAN_WORD_BITS-1:0] span;
    int node, d, lo, stop, slot;
    key = KEY_BITS'({$urandom, $urandom});
    node = int'(root_q);
    for (d = 0; d < LAYER_COUNT && node >= 0; d++) begin
      span = span_mem[d * NODES_PER_LAYER + node];
      lo = int'(span[SPAN_BITS-1:0]);
      stop = lo + int'(span[SPAN_WORD_BITS-1:SPAN_BITS]);
      if (stop > EDGES_PER_LAYER) stop = EDGES_PER_LAYER;
      if (lo < stop && $urandom_range(99, 0) >= 4) begin
        slot = $urandom_range(stop - 1, lo);
        key[SYMBOL_BITS*d +: SYMBOL_BITS] =
          edge_mem[d * EDGES_PER_LAYER + slot][SYMBOL_BITS-1:0];
      end
      node = search_layer(d, node, key[SYMBOL_BITS*d +: SYMBOL_BITS]);
    end
    return key;
  endfunction

  task automatic wait_loads();
    while (beat_queue.size() != 0 || s_valid_q) @(posedge clk_i);
  endtask

  task automatic wait_idle();
    while (beat_queue.size() != 0 || s_valid_q || verdict_fifo.size() != 0)
      @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_root(int v);
    wait_idle();
    @(posedge clk_i);
    cfg_we <= 1'b1;
    cfg_wdata <= NODE_BITS'(v);
    @(posedge clk_i);
    cfg_we <= 1'b0;
    root_q = NODE_BITS'(v);
    root_writes++;
  endtask

  initial begin
    logic [KEY_BITS-1:0] key;
    int d, p, n, node_id, sym;
    for (d = 0; d < LAYER_COUNT; d++) live_cnt[d] = 0;
    repeat (4) @(posedge clk_i);
    rst_n <= 1'b1;
    send_idle_pct = 37;
    recv_idle_pct = 84;
    set_root(0);

    add_noise_beat();
    add_node_beat(15, 5, 100, 1);
    add_node_beat(3, NODES_PER_LAYER, 200, 1);
    key = '0;
    for (d = 0; d < LAYER_COUNT; d++) begin
      node_id = (d % 2 == 1) ? NODES_PER_LAYER - 1 : 0;
      sym = (d == 0) ? 63 : (d == LAYER_COUNT - 1) ? 0 : d * 7;
      key[SYMBOL_BITS*d +: SYMBOL_BITS] = SYMBOL_BITS'(sym);
      add_live(d, node_id);
      if (d == 0) begin
        add_node_beat(0, node_id, EDGES_PER_LAYER - 1, 32767);
        add_edge_beat(0, EDGES_PER_LAYER - 1, sym, NODES_PER_LAYER - 1);
      end else begin
        add_node_beat(d, node_id, d * 100, 1);
        add_edge_beat(d, d * 100, sym, (d % 2 == 1) ? 0 : NODES_PER_LAYER - 1);
      end
    end
    add_lookup_beat(key);
    key[SYMBOL_BITS-1:0] = SYMBOL_BITS'(62);
    add_lookup_beat(key);
    key[SYMBOL_BITS-1:0] = SYMBOL_BITS'(63);
    key[KEY_BITS-1 -: SYMBOL_BITS] = SYMBOL_BITS'(1);
    add_lookup_beat(key);

    for (p = 0; p < PHASES; p++) begin
      send_idle_pct = (p < 2) ? 37 : (p < 4) ? 84 : 0;
      recv_idle_pct = (p < 2) ? 84 : (p < 4) ? 37 : 0;
      if (p == 0) set_root(NODES_PER_LAYER - 1);
      else if (p == 1) set_root(0);
      else set_root(pick_live(0));
      build_diagram(p == 0);
      wait_loads();
      n = 0;
      while (n < LOOKUPS_PER_PHASE) begin
        if ($urandom_range(99, 0) < 15) begin
          add_noise_beat();
        end else begin
          if ($urandom_range(99, 0) < 80) add_lookup_beat(trace_key());
          else add_lookup_beat(KEY_BITS'({$urandom, $urandom}));
          n++;
        end
      end
    end

    wait_idle();
    $display("Covered %0d table loads, %0d ignored beats and %0d lookups, %0d accepted,",
             load_beats, ignored_beats, lookup_beats, pass_lookups);
    $display("across %0d root settings and three back-pressure patterns; %0d mismatches.",
             root_writes, mismatches);
    if (mismatches == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule
